### src/rce_pkg.sv
// ----------------------------------------------------------------------------
// rce_pkg: shared types and constants of the radix conversion engine
// Value width, digit store depth, character codes, divider handshake structs,
// sequencer states and the digit/character mapping functions.
// ----------------------------------------------------------------------------
package rce_pkg;

	localparam int VALUE_BITS = 63;
	localparam int MAX_DIGITS = 64;

	localparam int BASE_W = 6;
	localparam int CH_W   = 8;

	// divider: DIV_STEP quotient bits per cycle
	localparam int DIV_STEP   = 8;
	localparam int DIV_CYCLES = (VALUE_BITS + DIV_STEP - 1) / DIV_STEP;
	localparam int DIV_W      = DIV_CYCLES * DIV_STEP;
	localparam int STEP_W     = $clog2(DIV_CYCLES + 1);

	localparam int ADDR_W = $clog2(MAX_DIGITS);
	localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
	localparam int PROD_W = VALUE_BITS + BASE_W;

	localparam logic [BASE_W-1:0] MIN_BASE     = BASE_W'(2);
	localparam logic [BASE_W-1:0] MAX_IN_BASE  = BASE_W'(35);
	localparam logic [BASE_W-1:0] MAX_OUT_BASE = BASE_W'(36);
	localparam logic [BASE_W-1:0] RST_IN_BASE  = BASE_W'(10);
	localparam logic [BASE_W-1:0] RST_OUT_BASE = BASE_W'(16);
	localparam logic [BASE_W-1:0] NO_DIGIT     = '1;

	localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CH_W-1:0] CH_0     = 8'h30;
	localparam logic [CH_W-1:0] CH_9     = 8'h39;
	localparam logic [CH_W-1:0] CH_UA    = 8'h41;
	localparam logic [CH_W-1:0] CH_UZ    = 8'h5A;
	localparam logic [CH_W-1:0] CH_LA    = 8'h61;
	localparam logic [CH_W-1:0] CH_LZ    = 8'h7A;
	localparam logic [CH_W-1:0] CH_NUL   = 8'h00;

	// configuration register indexes
	localparam logic REG_IN_BASE  = 1'b0;
	localparam logic REG_OUT_BASE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_READ,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic                  start;
		logic [VALUE_BITS-1:0] dividend;
		logic [BASE_W-1:0]     divisor;
	} div_ctrl_t;

	typedef struct packed {
		logic                  busy;
		logic                  done;
		logic [VALUE_BITS-1:0] quotient;
		logic [BASE_W-1:0]     remainder;
	} div_sts_t;

	// digit value of a character, NO_DIGIT if it is none
	function automatic logic [BASE_W-1:0] char_value(input logic [CH_W-1:0] c);
		logic [BASE_W-1:0] v;
		v = NO_DIGIT;
		if (c >= CH_0 && c <= CH_9)
			v = BASE_W'(c - CH_0);
		else if (c >= CH_UA && c <= CH_UZ)
			v = BASE_W'(c - CH_UA + 8'd10);
		else if (c >= CH_LA && c <= CH_LZ)
			v = BASE_W'(c - CH_LA + 8'd10);
		return v;
	endfunction

	function automatic logic [CH_W-1:0] digit_char(input logic [BASE_W-1:0] d);
		logic [CH_W-1:0] c;
		if (d < BASE_W'(10))
			c = CH_0 + CH_W'(d);
		else
			c = CH_UA + CH_W'(d) - 8'd10;
		return c;
	endfunction

endpackage

### src/rce_div.sv
// ----------------------------------------------------------------------------
// rce_div: iterative value-by-base divider
// Restoring division of a VALUE_BITS dividend by a small base, DIV_STEP
// quotient bits per cycle; quotient and remainder held until the next start.
// ----------------------------------------------------------------------------
module rce_div
	import rce_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  div_ctrl_t ctrl,
	output div_sts_t  sts
);

	logic [DIV_W-1:0]    work_q;
	logic [BASE_W-1:0]   rem_q;
	logic [BASE_W-1:0]   divisor_q;
	logic [STEP_W-1:0]   step_q;
	logic                busy_q;
	logic                done_q;

	logic [BASE_W:0]     r;
	logic [DIV_STEP-1:0] qbits;

	// DIV_STEP dependent compare/subtract steps on a 7-bit remainder
	always_comb begin
		r     = {1'b0, rem_q};
		qbits = '0;
		for (int i = 0; i < DIV_STEP; i++) begin
			r = {r[BASE_W-1:0], work_q[DIV_W-1-i]};
			if (r >= {1'b0, divisor_q}) begin
				r = r - {1'b0, divisor_q};
				qbits[DIV_STEP-1-i] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(DIV_CYCLES - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			work_q    <= DIV_W'(ctrl.dividend);
			rem_q     <= '0;
			divisor_q <= ctrl.divisor;
		end else if (busy_q) begin
			work_q <= {work_q[DIV_W-DIV_STEP-1:0], qbits};
			rem_q  <= r[BASE_W-1:0];
		end
	end

	assign sts.busy      = busy_q;
	assign sts.done      = done_q;
	assign sts.quotient  = work_q[VALUE_BITS-1:0];
	assign sts.remainder = rem_q;

endmodule

### src/radix_conversion_engine.sv
// ----------------------------------------------------------------------------
// radix_conversion_engine: ASCII number text to ASCII digits in another base
// Accumulates input digits with overflow and syntax checks, then splits the
// value into output-base digits and streams them most significant first.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------
//  in      | in_valid / in_stall  | ch[7:0], last
//  out     | out_valid / out_stall| symbol[7:0], invalid, last_out
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data[5:0]
//
//  A character that is not marked last is absorbed with one multiply-add.
//  A last character with D output digits runs D divisions in the shared
//  divider; each digit then passes the digit store read port (ST_READ, then
//  ST_EMIT), and output stalls hold the stream.
//  Reset is asynchronous; bases return to 10 and 16. No clearing pass.
//  in_stall stays high from the last character until the final result leaves.
// ----------------------------------------------------------------------------
module radix_conversion_engine
	import rce_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [CH_W-1:0]   ch,
	input  logic              last,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [CH_W-1:0]   symbol,
	output logic              invalid,
	output logic              last_out,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [BASE_W-1:0] cfg_data
);

	state_t                state_q, state_d;
	logic [BASE_W-1:0]     in_base_q, out_base_q;
	logic [VALUE_BITS-1:0] acc_q, acc_d;
	logic                  at_start_q, stopped_q, stopped_d, err_seen_q, err_seen_d;
	logic [CNT_W-1:0]      cnt_q;
	logic [ADDR_W-1:0]     ptr_q;
	logic                  bad_q;
	logic [BASE_W-1:0]     rd_q;
	logic [BASE_W-1:0]     store_mem [MAX_DIGITS];

	logic                  in_acc;
	logic                  in_bad, out_bad, bad_now;
	logic [BASE_W-1:0]     dval;
	logic [PROD_W-1:0]     mac;
	logic                  ovf;
	logic                  q_zero, full;
	div_ctrl_t             div_ctrl;
	div_sts_t              div_sts;

	rce_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (div_ctrl),
		.sts   (div_sts)
	);

	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && !in_stall;
	assign in_bad    = (in_base_q < MIN_BASE) || (in_base_q > MAX_IN_BASE);
	assign out_bad   = (out_base_q < MIN_BASE) || (out_base_q > MAX_OUT_BASE);
	assign dval      = char_value(ch);
	assign mac       = PROD_W'(acc_q) * PROD_W'(in_base_q) + PROD_W'(dval);
	assign ovf       = |mac[PROD_W-1:VALUE_BITS];
	assign q_zero    = (div_sts.quotient == '0);
	assign full      = (cnt_q + 1'b1) >= CNT_W'(MAX_DIGITS);

	// per-character parse
	always_comb begin
		acc_d      = acc_q;
		stopped_d  = stopped_q;
		err_seen_d = err_seen_q;
		if (stopped_q) begin
			stopped_d = 1'b1;
		end else if (at_start_q && ch == CH_MINUS) begin
			stopped_d = 1'b0;
		end else if (ch == CH_SPACE || ch == CH_TAB) begin
			stopped_d = 1'b1;
		end else if (in_bad || dval >= in_base_q) begin
			err_seen_d = 1'b1;
		end else if (!err_seen_q) begin
			if (ovf)
				err_seen_d = 1'b1;
			else
				acc_d = mac[VALUE_BITS-1:0];
		end
	end

	assign bad_now = err_seen_d || in_bad || out_bad;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && last)
					state_d = bad_now ? ST_EMIT : ST_DIV;
			end
			ST_DIV: begin
				if (div_sts.done) begin
					if (q_zero)
						state_d = ST_READ;
					else if (full)
						state_d = ST_EMIT;
				end
			end
			ST_READ: state_d = ST_EMIT;
			ST_EMIT: begin
				if (!out_stall)
					state_d = last_out ? ST_IDLE : ST_READ;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and divider control
	always_comb begin
		in_stall          = (state_q != ST_IDLE);
		out_valid         = (state_q == ST_EMIT);
		invalid           = bad_q;
		last_out          = bad_q || (ptr_q == '0);
		symbol            = bad_q ? CH_NUL : digit_char(rd_q);
		div_ctrl.divisor  = out_base_q;
		div_ctrl.dividend = (state_q == ST_IDLE) ? acc_d : div_sts.quotient;
		div_ctrl.start    = 1'b0;
		unique case (state_q)
			ST_IDLE: div_ctrl.start = in_acc && last && !bad_now;
			ST_DIV:  div_ctrl.start = div_sts.done && !q_zero && !full;
			ST_READ, ST_EMIT: div_ctrl.start = 1'b0;
			default: div_ctrl.start = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			in_base_q  <= RST_IN_BASE;
			out_base_q <= RST_OUT_BASE;
			acc_q      <= '0;
			at_start_q <= 1'b1;
			stopped_q  <= 1'b0;
			err_seen_q <= 1'b0;
			cnt_q      <= '0;
			ptr_q      <= '0;
			bad_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_IN_BASE:  in_base_q  <= cfg_data;
					REG_OUT_BASE: out_base_q <= cfg_data;
					default: ;
				endcase
			end
			if (in_acc) begin
				if (last) begin
					acc_q      <= '0;
					at_start_q <= 1'b1;
					stopped_q  <= 1'b0;
					err_seen_q <= 1'b0;
					cnt_q      <= '0;
					bad_q      <= bad_now;
				end else begin
					acc_q      <= acc_d;
					at_start_q <= 1'b0;
					stopped_q  <= stopped_d;
					err_seen_q <= err_seen_d;
				end
			end
			if (state_q == ST_DIV && div_sts.done) begin
				cnt_q <= cnt_q + 1'b1;
				if (q_zero)
					ptr_q <= cnt_q[ADDR_W-1:0];
				else if (full)
					bad_q <= 1'b1;
			end
			if (state_q == ST_EMIT && !out_stall) begin
				if (last_out)
					bad_q <= 1'b0;
				else
					ptr_q <= ptr_q - 1'b1;
			end
		end
	end

	// digit store: remainders land least significant first
	always_ff @(posedge clk) begin
		if (state_q == ST_DIV && div_sts.done)
			store_mem[cnt_q[ADDR_W-1:0]] <= div_sts.remainder;
		if (state_q == ST_READ)
			rd_q <= store_mem[ptr_q];
	end

	a_no_emit_while_div: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !div_sts.busy)
		else $error("result shown while divider busy");

	a_no_result_midtext: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !last) |=> !out_valid)
		else $error("result after a non-final character");

	a_invalid_form: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && invalid) |-> (last_out && symbol == CH_NUL))
		else $error("invalid result not a single terminal transaction");

	a_symbol_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !invalid) |->
			((symbol >= CH_0 && symbol <= CH_9) || (symbol >= CH_UA && symbol <= CH_UZ)))
		else $error("symbol outside digit set");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_DIGITS))
		else $error("digit count beyond store depth");

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb: radix conversion engine testbench
// Sends number text one character per transaction and checks every emitted
// digit against a behavioral model of the base conversion or against a short
// table of signs, stops, bad characters and bad bases. Random numbers then
// run under changing base settings, with bursts of idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import rce_pkg::*;

	localparam int          RAND_ITEMS   = 170;
	localparam int          DRAIN_CYCLES = 8;
	localparam logic [63:0] VALUE_MAX    = (64'd1 << VALUE_BITS) - 64'd1;

	typedef struct packed {
		logic [CH_W-1:0] symbol;
		logic            invalid;
		logic            last_out;
	} digit_out_t;

	typedef enum {BY_MODEL, TYPED, REJECT} row_check_t;

	typedef struct {
		logic [BASE_W-1:0] ib;
		logic [BASE_W-1:0] ob;
		int                len;
		logic [127:0]      txt;
		row_check_t        how;
		int                want_len;
		logic [127:0]      want;
	} text_row_t;

	// text is right-aligned: the first character sits in the highest used byte
	text_row_t dir_rows [10] = '{
		'{RST_IN_BASE, RST_OUT_BASE, 4, "-255", TYPED, 2, "FF"},
		'{6'd10, 6'd16, 2, "1-", REJECT, 0, 0},
		'{6'd10, 6'd16, 2, " Z", TYPED, 1, "0"},
		'{6'd10, 6'd16, 2, 128'h09FF, TYPED, 1, "0"},
		'{6'd10, 6'd16, 1, 128'hFF, REJECT, 0, 0},
		'{6'd10, 6'd16, 1, 128'h00, REJECT, 0, 0},
		'{6'd36, 6'd16, 1, "1", REJECT, 0, 0},
		'{6'd2, 6'd63, 1, "1", REJECT, 0, 0},
		'{6'd35, 6'd36, 1, "Z", REJECT, 0, 0},
		'{6'd32, 6'd2, 13, "7vvvvvvvvvvvv", BY_MODEL, 0, 0}
	};

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_stall;
	logic [CH_W-1:0]   ch        = '0;
	logic              last      = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [CH_W-1:0]   symbol;
	logic              invalid;
	logic              last_out;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic              cfg_index = REG_IN_BASE;
	logic [BASE_W-1:0] cfg_data  = '0;

	// model of the block
	logic [BASE_W-1:0] mdl_in_base  = RST_IN_BASE;
	logic [BASE_W-1:0] mdl_out_base = RST_OUT_BASE;
	logic [63:0]       run_value    = '0;
	bit                run_fresh    = 1'b1;
	bit                run_halted   = 1'b0;
	bit                run_fault    = 1'b0;

	digit_out_t pending_digits [$];
	int         fails      = 0;
	bit         calm       = 1'b0;
	int         stall_left = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	radix_conversion_engine i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.ch        (ch),
		.last      (last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.symbol    (symbol),
		.invalid   (invalid),
		.last_out  (last_out),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	function automatic int unsigned digit_of(input logic [CH_W-1:0] c);
		if (c >= CH_0 && c <= CH_9)
			return 32'(c - CH_0);
		if (c >= CH_UA && c <= CH_UZ)
			return c - CH_UA + 10;
		if (c >= CH_LA && c <= CH_LZ)
			return c - CH_LA + 10;
		return 255;
	endfunction

	function automatic logic [CH_W-1:0] ascii_of(input logic [BASE_W-1:0] d);
		if (d < 10)
			return CH_0 + CH_W'(d);
		return CH_UA + CH_W'(d) - 8'd10;
	endfunction

	function automatic void restart_run();
		run_value  = '0;
		run_fresh  = 1'b1;
		run_halted = 1'b0;
		run_fault  = 1'b0;
	endfunction

	function automatic void absorb_char(input logic [CH_W-1:0] c);
		logic [63:0] d;
		logic [63:0] b;
		bit          first;
		first     = run_fresh;
		run_fresh = 1'b0;
		d         = 64'(digit_of(c));
		b         = 64'(mdl_in_base);
		if (run_halted || (first && c == CH_MINUS))
			return;
		if (c == CH_SPACE || c == CH_TAB) begin
			run_halted = 1'b1;
			return;
		end
		if (b < MIN_BASE || b > MAX_IN_BASE || d >= b) begin
			run_fault = 1'b1;
			return;
		end
		if (run_fault)
			return;
		if (run_value > (VALUE_MAX - d) / b)
			run_fault = 1'b1;
		else
			run_value = run_value * b + d;
	endfunction

	// converts the finished value and queues its digits, most significant first, or a single invalid entry for a bad run
	function automatic void emit_digits();
		logic [63:0]       v;
		logic [BASE_W-1:0] digs [$];
		bit                bad;
		bad = run_fault || mdl_in_base < MIN_BASE || mdl_in_base > MAX_IN_BASE ||
			mdl_out_base < MIN_BASE || mdl_out_base > MAX_OUT_BASE;
		v = run_value;
		if (bad) begin
			pending_digits.push_back(digit_out_t'{8'h00, 1'b1, 1'b1});
		end else begin
			if (v == 0)
				digs.push_back('0);
			while (v != 0) begin
				digs.push_back(BASE_W'(v % 64'(mdl_out_base)));
				v = v / 64'(mdl_out_base);
			end
			for (int k = digs.size() - 1; k >= 0; k--)
				pending_digits.push_back(digit_out_t'{ascii_of(digs[k]), 1'b0, k == 0});
		end
		restart_run();
	endfunction

	function automatic logic [CH_W-1:0] rand_digit(input int unsigned span);
		int unsigned d;
		d = $urandom_range(0, span - 1);
		if (d < 10)
			return CH_0 + CH_W'(d);
		if ($urandom_range(0, 1) == 0)
			return CH_UA + CH_W'(d - 10);
		return CH_LA + CH_W'(d - 10);
	endfunction

	task automatic send_char(input logic [CH_W-1:0] c, input logic fin);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		ch       <= c;
		last     <= fin;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		absorb_char(c);
	endtask

	// only while idle: drain, let the last character settle, then write both
	task automatic set_bases(input logic [BASE_W-1:0] ib, input logic [BASE_W-1:0] ob);
		in_valid <= 1'b0;
		while (pending_digits.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= REG_IN_BASE;
		cfg_data  <= ib;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		mdl_in_base = ib;
		cfg_index <= REG_OUT_BASE;
		cfg_data  <= ob;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		mdl_out_base = ob;
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall  <= 1'b1;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 3);
			out_stall  <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		digit_out_t want;
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			if (pending_digits.size() == 0) begin
				$error("unexpected transaction: symbol %h invalid %b last_out %b",
					symbol, invalid, last_out);
				fails++;
			end else begin
				want = pending_digits.pop_front();
				if (symbol !== want.symbol) begin
					$error("symbol: expected %h, got %h", want.symbol, symbol);
					fails++;
				end
				if (invalid !== want.invalid) begin
					$error("invalid: expected %b, got %b", want.invalid, invalid);
					fails++;
				end
				if (last_out !== want.last_out) begin
					$error("last_out: expected %b, got %b", want.last_out, last_out);
					fails++;
				end
			end
		end
	end

	initial begin
		logic [CH_W-1:0]   txtq [$];
		logic [BASE_W-1:0] ib;
		logic [BASE_W-1:0] ob;
		int unsigned       span;
		int                sel;
		int                kind;
		int                n_items;
		int                num_idx;

		n_items = 0;
		num_idx = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r]) begin
			if (dir_rows[r].ib != mdl_in_base || dir_rows[r].ob != mdl_out_base)
				set_bases(dir_rows[r].ib, dir_rows[r].ob);
			for (int i = 0; i < dir_rows[r].len; i++)
				send_char(dir_rows[r].txt[8 * (dir_rows[r].len - 1 - i) +: 8],
					i == dir_rows[r].len - 1);
			case (dir_rows[r].how)
				BY_MODEL: emit_digits();
				REJECT: begin
					pending_digits.push_back(digit_out_t'{8'h00, 1'b1, 1'b1});
					restart_run();
				end
				default: begin
					for (int i = 0; i < dir_rows[r].want_len; i++)
						pending_digits.push_back(digit_out_t'{
							dir_rows[r].want[8 * (dir_rows[r].want_len - 1 - i) +: 8],
							1'b0, i == dir_rows[r].want_len - 1});
					restart_run();
				end
			endcase
		end

		while (n_items < RAND_ITEMS) begin
			if (num_idx % 6 == 0) begin
				sel = $urandom_range(0, 19);
				if (sel < 3)       ib = 6'd2;
				else if (sel < 6)  ib = 6'd35;
				else if (sel < 9)  ib = 6'd32;
				else if (sel < 11) ib = 6'd10;
				else if (sel < 16) ib = 6'($urandom_range(2, 35));
				else if (sel == 16) ib = 6'd36;
				else if (sel == 17) ib = 6'($urandom_range(0, 1));
				else if (sel == 18) ib = 6'($urandom_range(37, 63));
				else               ib = 6'd16;
				sel = $urandom_range(0, 19);
				if (sel < 4)       ob = 6'd2;
				else if (sel < 7)  ob = 6'd36;
				else if (sel < 9)  ob = 6'd16;
				else if (sel < 17) ob = 6'($urandom_range(2, 36));
				else if (sel == 17) ob = 6'($urandom_range(0, 1));
				else if (sel == 18) ob = 6'($urandom_range(37, 63));
				else               ob = 6'd10;
				set_bases(ib, ob);
			end
			// last stretch of the run goes without idling
			calm = (n_items > RAND_ITEMS * 4 / 5) || ($urandom_range(0, 4) == 0);
			span = (mdl_in_base >= MIN_BASE && mdl_in_base <= MAX_IN_BASE) ? mdl_in_base : 36;
			kind = $urandom_range(0, 9);
			txtq.delete();
			if (kind == 9) begin
				// stray bytes, mostly no digits at all
				repeat ($urandom_range(1, 3))
					txtq.push_back(8'($urandom_range(0, 255)));
				n_items += txtq.size();
			end else begin
				if ($urandom_range(0, 3) == 0)
					txtq.push_back(CH_MINUS);
				if (kind == 8) begin
					// thirteen digits, near or past the top of the value range for large bases
					if (span == 32 && $urandom_range(0, 1) == 0)
						txtq.push_back(CH_0 + 8'd7);
					else
						txtq.push_back(rand_digit(span));
					repeat (12) txtq.push_back(rand_digit(span));
				end else begin
					repeat ($urandom_range(0, 12)) txtq.push_back(rand_digit(span));
				end
				if (kind == 7 && txtq.size() != 0)
					txtq[$urandom_range(0, txtq.size() - 1)] = 8'($urandom_range(0, 255));
				if (txtq.size() == 0)
					txtq.push_back(rand_digit(span));
				n_items += txtq.size();
				if ($urandom_range(0, 3) == 0) begin
					txtq.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
					repeat ($urandom_range(0, 3))
						txtq.push_back(8'($urandom_range(0, 255)));
				end
			end
			foreach (txtq[i])
				send_char(txtq[i], i == txtq.size() - 1);
			emit_digits();
			num_idx++;
		end

		in_valid <= 1'b0;
		calm = 1'b1;
		while (pending_digits.size() != 0)
			@(posedge clk);
		repeat (4 * DRAIN_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
